@@ design/uart_buffer_queues_with_rts_unit_assert.svh @@
// Assertion macros shared by the UART ring buffer design.
`ifndef UART_BUFFER_QUEUES_WITH_RTS_UNIT_ASSERT_SVH
`define UART_BUFFER_QUEUES_WITH_RTS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define UBQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UBQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define UBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ design/ubq_pkg.sv @@
// Shared constants and beat types of the UART ring buffer block.
`default_nettype none

package ubq_pkg;

    // Slots per ring; one slot always stays empty.
    localparam int DEPTH  = 64;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = PTR_W + 1;
    localparam int HW_W   = 6;
    localparam int CMP_W  = (FILL_W > HW_W) ? FILL_W : HW_W;
    localparam int BYTE_W = 8;

    localparam logic [HW_W-1:0] HW_RESET = HW_W'(48);

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_RECV  = 2'd2,
        CMD_TXRDY = 2'd3
    } t_cmd_e;

    typedef struct packed {
        t_cmd_e              command;
        logic [BYTE_W-1:0]   data_byte;
    } t_in;

    typedef struct packed {
        logic                accepted;
        logic [BYTE_W-1:0]   read_byte;
        logic                send_valid;
        logic [BYTE_W-1:0]   send_byte;
        logic                rts_stop;
        logic                overflow_flag;
        logic                receive_empty;
        logic                transmit_armed;
    } t_out;

endpackage

`default_nettype wire

@@ design/ubq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ubq_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/uart_buffer_queues_with_rts_unit.sv @@
// Top level of the UART transmit/receive ring buffers with RTS flow control.
`default_nettype none
`include "uart_buffer_queues_with_rts_unit_assert.svh"

// This block keeps a transmit ring and a receive ring between a CPU and a
// UART, each of DEPTH byte slots held in a synchronous RAM, with one slot
// always left empty so a ring holds at most DEPTH-1 bytes. A command beat is
// taken when start is high and busy is low. For each command:
// in the accept cycle the ring pointers, flags and RTS state are updated and
// the RAM access is issued, and in the next cycle the RAM read data comes
// back and the result beat is shown on o_res for exactly that one cycle,
// marked by o_res_valid. The result cannot be held off, so the receiver must
// sample it in that cycle. Busy is high during the result cycle, so no new
// command is taken before the result is out, because the RAM read is
// registered. The high-water register may be written at any time through the
// configuration channel, which is always ready, but should only change while
// no command is in flight. The RAMs need no clearing pass after reset,
// since a ring only reads slots it has written.
module uart_buffer_queues_with_rts_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  ubq_pkg::t_in            i_cmd,
    output logic                    o_res_valid,
    output ubq_pkg::t_out           o_res,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [ubq_pkg::HW_W-1:0] i_cfg_data
);

    import ubq_pkg::*;

    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == LAST_POS) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    // Ring pointers and flags.
    logic [PTR_W-1:0] r_tx_wr, n_tx_wr;
    logic [PTR_W-1:0] r_tx_rd, n_tx_rd;
    logic [PTR_W-1:0] r_rx_wr, n_rx_wr;
    logic [PTR_W-1:0] r_rx_rd, n_rx_rd;
    logic             r_armed, n_armed;
    logic             r_lost, n_lost;
    logic             r_stop, n_stop;
    logic [HW_W-1:0]  r_hw;

    // Result-cycle control.
    logic             r_pend;
    logic             r_acc, n_acc;
    logic             r_get, n_get;
    logic             r_send, n_send;

    logic             accept;
    logic [PTR_W-1:0] tx_wr_nx, tx_rd_nx, rx_wr_nx, rx_rd_nx;
    logic             tx_full, tx_empty, rx_full, rx_empty;
    logic [PTR_W-1:0] fill_wr, fill_rd;
    logic [FILL_W-1:0] fill;
    logic             fill_above;

    logic             tx_we, tx_re, rx_we, rx_re;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    assign accept   = start && !r_pend;

    assign tx_wr_nx = ptr_next(r_tx_wr);
    assign tx_rd_nx = ptr_next(r_tx_rd);
    assign rx_wr_nx = ptr_next(r_rx_wr);
    assign rx_rd_nx = ptr_next(r_rx_rd);

    assign tx_full  = (tx_wr_nx == r_tx_rd);
    assign tx_empty = (r_tx_wr == r_tx_rd);
    assign rx_full  = (rx_wr_nx == r_rx_rd);
    assign rx_empty = (r_rx_wr == r_rx_rd);

    // Receive fill level as it stands after this command; only a stored
    // receive or a successful get moves a receive pointer.
    assign fill_wr = (i_cmd.command == CMD_RECV && !rx_full)  ? rx_wr_nx : r_rx_wr;
    assign fill_rd = (i_cmd.command == CMD_GET  && !rx_empty) ? rx_rd_nx : r_rx_rd;

    always_comb begin
        if (fill_wr >= fill_rd) begin
            fill = FILL_W'(fill_wr) - FILL_W'(fill_rd);
        end else begin
            fill = FILL_W'(fill_wr) + FILL_W'(DEPTH) - FILL_W'(fill_rd);
        end
    end

    assign fill_above = CMP_W'(fill) > CMP_W'(r_hw);

    always_comb begin
        n_tx_wr = r_tx_wr;
        n_tx_rd = r_tx_rd;
        n_rx_wr = r_rx_wr;
        n_rx_rd = r_rx_rd;
        n_armed = r_armed;
        n_lost  = r_lost;
        n_stop  = r_stop;
        n_acc   = 1'b0;
        n_get   = 1'b0;
        n_send  = 1'b0;
        tx_we   = 1'b0;
        tx_re   = 1'b0;
        rx_we   = 1'b0;
        rx_re   = 1'b0;
        if (accept) begin
            case (i_cmd.command)
                CMD_PUT: begin
                    if (!tx_full) begin
                        tx_we   = 1'b1;
                        n_tx_wr = tx_wr_nx;
                        n_armed = 1'b1;
                        n_acc   = 1'b1;
                    end
                end
                CMD_GET: begin
                    if (!rx_empty) begin
                        rx_re   = 1'b1;
                        n_rx_rd = rx_rd_nx;
                        n_acc   = 1'b1;
                        n_get   = 1'b1;
                        if (!fill_above) begin
                            n_stop = 1'b0;
                        end
                    end
                end
                CMD_RECV: begin
                    if (!rx_full) begin
                        rx_we   = 1'b1;
                        n_rx_wr = rx_wr_nx;
                        n_acc   = 1'b1;
                    end else begin
                        n_lost = 1'b1;
                    end
                    if (fill_above) begin
                        n_stop = 1'b1;
                    end
                end
                CMD_TXRDY: begin
                    if (r_armed) begin
                        if (!tx_empty) begin
                            tx_re   = 1'b1;
                            n_tx_rd = tx_rd_nx;
                            n_send  = 1'b1;
                            n_acc   = 1'b1;
                        end else begin
                            n_armed = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_wr <= '0;
            r_tx_rd <= '0;
            r_rx_wr <= '0;
            r_rx_rd <= '0;
            r_armed <= 1'b0;
            r_lost  <= 1'b0;
            r_stop  <= 1'b0;
            r_hw    <= HW_RESET;
            r_pend  <= 1'b0;
            r_acc   <= 1'b0;
            r_get   <= 1'b0;
            r_send  <= 1'b0;
        end else begin
            r_tx_wr <= n_tx_wr;
            r_tx_rd <= n_tx_rd;
            r_rx_wr <= n_rx_wr;
            r_rx_rd <= n_rx_rd;
            r_armed <= n_armed;
            r_lost  <= n_lost;
            r_stop  <= n_stop;
            r_pend  <= accept;
            if (accept) begin
                r_acc  <= n_acc;
                r_get  <= n_get;
                r_send <= n_send;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_hw <= i_cfg_data;
            end
        end
    end

    // Transmit ring storage: written by a put, read by a transmitter-ready.
    ubq_ram #(
        .W (BYTE_W),
        .D (DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (i_cmd.data_byte),
        .i_re    (tx_re),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_rdata)
    );

    // Receive ring storage: written by a line receive, read by a get.
    ubq_ram #(
        .W (BYTE_W),
        .D (DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (i_cmd.data_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_rdata)
    );

    assign busy        = r_pend;
    assign o_res_valid = r_pend;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_res.accepted       = r_acc;
        o_res.read_byte      = r_get  ? rx_rdata : '0;
        o_res.send_valid     = r_send;
        o_res.send_byte      = r_send ? tx_rdata : '0;
        o_res.rts_stop       = r_stop;
        o_res.overflow_flag  = r_lost;
        o_res.receive_empty  = (r_rx_wr == r_rx_rd);
        o_res.transmit_armed = r_armed;
    end

    `UBQ_ASSERT_NEXT(a_res_after_accept, i_clk, i_rst_n, start && !busy, o_res_valid, "result beat missing after accepted command")
    `UBQ_ASSERT_NEXT(a_res_single, i_clk, i_rst_n, o_res_valid, !o_res_valid, "result beat lasted more than one cycle")
    `UBQ_ASSERT_NOW(a_send_armed, i_clk, i_rst_n, o_res_valid && o_res.send_valid, o_res.transmit_armed && o_res.accepted, "byte sent while transmitter disarmed")
    `UBQ_ASSERT_NEXT(a_lost_sticky, i_clk, i_rst_n, r_lost, r_lost, "overflow flag cleared without reset")

endmodule

`default_nettype wire

@@ verif/uart_buffer_queues_with_rts_unit_tb.sv @@
// Self-checking testbench of the UART ring buffer block with RTS flow control.
module uart_buffer_queues_with_rts_unit_tb;
    import ubq_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT = 1000;

    // Mirrors both rings, the transmitter arming, the sticky overflow and the
    // RTS state, and keeps the result beats it expects in order of issue.
    class ubq_scoreboard;
        logic [BYTE_W-1:0] tx_ring [DEPTH];
        logic [BYTE_W-1:0] rx_ring [DEPTH];
        int                tx_wr, tx_rd, rx_wr, rx_rd;
        bit                armed, lost, stop;
        logic [HW_W-1:0]   rts_mark;
        t_out              result_q [$];
        int                mismatches;

        function new();
            tx_wr = 0;
            tx_rd = 0;
            rx_wr = 0;
            rx_rd = 0;
            armed = 1'b0;
            lost = 1'b0;
            stop = 1'b0;
            rts_mark = HW_RESET;
            mismatches = 0;
        endfunction

        function int next_slot(int p);
            return (p + 1 >= DEPTH) ? 0 : p + 1;
        endfunction

        function int rx_fill();
            return (rx_wr + DEPTH - rx_rd) % DEPTH;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function void set_rts_mark(logic [HW_W-1:0] v);
            rts_mark = v;
        endfunction

        // Applies one accepted command beat and queues the result it causes.
        function void note_command(t_in c);
            t_out r;
            r = '0;
            case (c.command)
                CMD_PUT: begin
                    if (next_slot(tx_wr) != tx_rd) begin
                        tx_ring[PTR_W'(tx_wr)] = c.data_byte;
                        tx_wr = next_slot(tx_wr);
                        armed = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
                CMD_GET: begin
                    if (rx_wr != rx_rd) begin
                        r.read_byte = rx_ring[PTR_W'(rx_rd)];
                        rx_rd = next_slot(rx_rd);
                        r.accepted = 1'b1;
                        if (rx_fill() <= int'(rts_mark)) stop = 1'b0;
                    end
                end
                CMD_RECV: begin
                    if (next_slot(rx_wr) != rx_rd) begin
                        rx_ring[PTR_W'(rx_wr)] = c.data_byte;
                        rx_wr = next_slot(rx_wr);
                        r.accepted = 1'b1;
                    end else begin
                        lost = 1'b1;
                    end
                    if (rx_fill() > int'(rts_mark)) stop = 1'b1;
                end
                default: begin
                    if (armed) begin
                        if (tx_wr != tx_rd) begin
                            r.send_byte = tx_ring[PTR_W'(tx_rd)];
                            tx_rd = next_slot(tx_rd);
                            r.send_valid = 1'b1;
                            r.accepted = 1'b1;
                        end else begin
                            armed = 1'b0;
                        end
                    end
                end
            endcase
            r.rts_stop = stop;
            r.overflow_flag = lost;
            r.receive_empty = (rx_wr == rx_rd);
            r.transmit_armed = armed;
            result_q.push_back(r);
        endfunction

        function void report(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            mismatches++;
        endfunction

        function void field(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
            if (got !== want) report(what, got, want);
        endfunction

        // Compares one result beat with the oldest expectation.
        function void check_result(t_out got);
            t_out want;
            if (result_q.size() == 0) begin
                report("result with nothing expected", got.read_byte, '0);
                return;
            end
            want = result_q.pop_front();
            field("accepted", BYTE_W'(got.accepted), BYTE_W'(want.accepted));
            field("read_byte", got.read_byte, want.read_byte);
            field("send_valid", BYTE_W'(got.send_valid), BYTE_W'(want.send_valid));
            field("send_byte", got.send_byte, want.send_byte);
            field("rts_stop", BYTE_W'(got.rts_stop), BYTE_W'(want.rts_stop));
            field("overflow_flag", BYTE_W'(got.overflow_flag),
                  BYTE_W'(want.overflow_flag));
            field("receive_empty", BYTE_W'(got.receive_empty),
                  BYTE_W'(want.receive_empty));
            field("transmit_armed", BYTE_W'(got.transmit_armed),
                  BYTE_W'(want.transmit_armed));
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_in             i_cmd;
    logic            o_res_valid;
    t_out            o_res;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [HW_W-1:0] i_cfg_data;

    ubq_scoreboard   ring_model;
    bit              gaps_on;
    int              quiet_cycles;

    uart_buffer_queues_with_rts_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result beats last one cycle and cannot be stalled, so every cycle with
    // the strobe high is a beat. Signals are read right after the edge, before
    // the block's own updates land, which gives the values that the edge saw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) ring_model.check_result(o_res);
    end

    // The watchdog restarts on any beat in either direction or on the config
    // channel. A block that neither takes commands nor answers trips it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Lowers start and waits until every result beat issued so far is back.
    // The first edge is always taken so that start is assigned once per step.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (ring_model.pending() != 0) @(posedge i_clk);
    endtask

    // Offers one command beat, with random idle cycles first when gaps are on.
    // The beat is taken at the first edge at which busy was low.
    task automatic send_command(t_cmd_e cmd, logic [BYTE_W-1:0] data);
        t_in beat;
        beat.command = cmd;
        beat.data_byte = data;
        if (gaps_on && $urandom_range(0, 59) == 0) wait_for_results();
        while (gaps_on && $urandom_range(0, 99) < 28) begin
            // Idle cycles carry junk on the command bus to show it is ignored.
            start <= 1'b0;
            i_cmd <= t_in'($urandom);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= beat;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ring_model.note_command(beat);
    endtask

    // Changes the RTS mark once the block is idle. Every command yields a
    // result, so after the last one the block holds nothing.
    task automatic write_rts_mark(logic [HW_W-1:0] level);
        wait_for_results();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= level;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ring_model.set_rts_mark(level);
    endtask

    // Picks a command by the given weights, in percent of the whole.
    function automatic t_cmd_e pick_command(int w_put, int w_get, int w_recv);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_put) return CMD_PUT;
        if (r < w_put + w_get) return CMD_GET;
        if (r < w_put + w_get + w_recv) return CMD_RECV;
        return CMD_TXRDY;
    endfunction

    // One random phase: a high-water setting, a command mix that steers the
    // rings toward full or empty, and random bytes.
    task automatic run_phase(logic [HW_W-1:0] level, int w_put, int w_get, int w_recv,
                             int count, bit gaps);
        write_rts_mark(level);
        gaps_on = gaps;
        repeat (count) send_command(pick_command(w_put, w_get, w_recv), BYTE_W'($urandom));
    endtask

    initial begin
        ring_model = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        quiet_cycles = 0;
        gaps_on = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset high-water mark. It covers a get from
        // the empty receive ring, a transmitter-ready event while not armed,
        // puts that arm the transmitter, sending until the ring runs dry and
        // the transmitter disarms, and byte extremes through both rings.
        send_command(CMD_GET, 8'h00);
        send_command(CMD_TXRDY, 8'hff);
        send_command(CMD_PUT, 8'h00);
        send_command(CMD_PUT, 8'hff);
        send_command(CMD_PUT, 8'ha5);
        send_command(CMD_TXRDY, 8'h00);
        send_command(CMD_TXRDY, 8'h00);
        send_command(CMD_TXRDY, 8'h00);
        send_command(CMD_TXRDY, 8'h00);
        send_command(CMD_TXRDY, 8'h00);
        send_command(CMD_RECV, 8'hff);
        send_command(CMD_RECV, 8'h00);
        send_command(CMD_RECV, 8'h5a);
        send_command(CMD_GET, 8'hff);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_PUT, 8'h5a);
        send_command(CMD_RECV, 8'h81);

        // A zero mark raises RTS on any stored byte and drops it only when
        // the ring is empty again.
        run_phase(HW_W'(0), 25, 25, 25, 100, 1'b1);
        // Receive-heavy at the top mark: the receive ring fills, bytes are
        // lost to a full ring, and RTS can never rise.
        run_phase(HW_W'(63), 15, 10, 65, 150, 1'b1);
        // Drain from a full ring just one above the mark, with no idle
        // cycles at all, so RTS is set by a lost byte and cleared by gets.
        run_phase(HW_W'(62), 5, 60, 25, 120, 1'b0);
        // Put-heavy: the transmit ring fills and puts to it are dropped.
        run_phase(HW_W'(20), 65, 10, 15, 150, 1'b1);
        // Transmitter-heavy at a random mark: the transmit ring drains and
        // the transmitter disarms repeatedly.
        run_phase(HW_W'($urandom_range(0, 63)), 20, 15, 15, 100, 1'b1);
        // Back to the reset mark with an even mix.
        run_phase(HW_RESET, 25, 25, 25, 80, 1'b1);

        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (ring_model.mismatches == 0 && ring_model.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
